// ----- rtl/core/b2a_pkg.sv -----
// Package for the binary to ASCII number formatter.
// Holds field widths, ASCII codes and small helper functions.
// No dependencies.
`default_nettype none

package b2a_pkg;

  localparam int DEF_VALUE_BITS = 64;
  localparam int IN_VALUE_W     = 64;
  localparam int CHAR_W         = 7;

  localparam logic [CHAR_W-1:0] CH_ZERO   = 7'h30;
  localparam logic [CHAR_W-1:0] CH_X      = 7'h78;
  localparam logic [CHAR_W-1:0] HEX_ALPHA = 7'h57;

  localparam logic FMT_DEC = 1'b0;
  localparam logic FMT_HEX = 1'b1;

  // Number of decimal digits of 2^n - 1, from n * log10(2).
  function automatic int dec_digits(input int n);
    return (n * 30103) / 100000 + 1;
  endfunction

  function automatic logic [CHAR_W-1:0] nib_to_ascii(input logic [3:0] nib);
    logic [CHAR_W-1:0] ext;
    ext = CHAR_W'(nib);
    return (nib > 4'd9) ? ext + HEX_ALPHA : ext + CH_ZERO;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/binary_to_ascii_number_formatter.sv -----
// Decimal items run a bit-serial double-dabble conversion over VALUE_BITS input bits, then drop
// leading zeros, then emit one character per cycle while the receiver is ready; hex items emit
// a "0x" prefix and then all HEX_DIGITS digits. A new number is accepted only when the formatter
// is idle again, after the last character of the previous one has been loaded for output.
// Reset: synchronous, active low; clears the state machine and the output valid flag.
// Depends on b2a_pkg.
`default_nettype none

module binary_to_ascii_number_formatter #(
  parameter int VALUE_BITS = b2a_pkg::DEF_VALUE_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_cmd,
  input  wire logic [b2a_pkg::IN_VALUE_W-1:0] in_value,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [b2a_pkg::CHAR_W-1:0]         out_char_code,
  output logic                               out_last
);

  import b2a_pkg::*;

  localparam int DEC_DIGITS = dec_digits(VALUE_BITS);
  localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
  localparam int DW         = 4 * DEC_DIGITS;
  localparam int HW         = 4 * HEX_DIGITS;
  localparam int CW         = $clog2(VALUE_BITS);
  localparam int RW         = $clog2(DEC_DIGITS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_SKIP,
    S_PRE0,
    S_PREX,
    S_EMIT
  } state_t;

  state_t                fsm_r;
  logic [VALUE_BITS-1:0] bin_r;
  logic [DW-1:0]         dig_r;
  logic [CW-1:0]         cnt_r;
  logic [RW-1:0]         rem_r;
  logic                  out_valid_r;
  logic [CHAR_W-1:0]     out_char_r;
  logic                  out_last_r;

  logic [DW-1:0] dab;
  logic [HW-1:0] hex_val;
  logic [3:0]    top_nib;
  logic          out_free;
  logic          out_load;

  // Add three to every BCD digit of five or more before the shift.
  always_comb begin
    dab = dig_r;
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (dig_r[4*i +: 4] >= 4'd5) begin
        dab[4*i +: 4] = dig_r[4*i +: 4] + 4'd3;
      end
    end
  end

  assign hex_val  = HW'(in_value[VALUE_BITS-1:0]);
  assign top_nib  = dig_r[DW-1 -: 4];
  assign out_free = !out_valid_r || out_ready;
  assign out_load = out_free && (fsm_r == S_PRE0 || fsm_r == S_PREX || fsm_r == S_EMIT);
  assign in_ready = (fsm_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r       <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (fsm_r)
        S_IDLE: begin
          if (in_valid) begin
            if (in_cmd == FMT_HEX) begin
              dig_r <= {hex_val, {(DW-HW){1'b0}}};
              rem_r <= RW'(HEX_DIGITS);
              fsm_r <= S_PRE0;
            end else begin
              bin_r <= in_value[VALUE_BITS-1:0];
              dig_r <= '0;
              cnt_r <= '0;
              fsm_r <= S_CONV;
            end
          end
        end
        S_CONV: begin
          dig_r <= {dab[DW-2:0], bin_r[VALUE_BITS-1]};
          bin_r <= {bin_r[VALUE_BITS-2:0], 1'b0};
          cnt_r <= cnt_r + CW'(1);
          if (cnt_r == CW'(VALUE_BITS - 1)) begin
            rem_r <= RW'(DEC_DIGITS);
            fsm_r <= S_SKIP;
          end
        end
        S_SKIP: begin
          if (top_nib == 4'd0 && rem_r > RW'(1)) begin
            dig_r <= {dig_r[DW-5:0], 4'd0};
            rem_r <= rem_r - RW'(1);
          end else begin
            fsm_r <= S_EMIT;
          end
        end
        S_PRE0: begin
          if (out_free) begin
            out_char_r <= CH_ZERO;
            out_last_r <= 1'b0;
            fsm_r      <= S_PREX;
          end
        end
        S_PREX: begin
          if (out_free) begin
            out_char_r <= CH_X;
            out_last_r <= 1'b0;
            fsm_r      <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_char_r <= nib_to_ascii(top_nib);
            out_last_r <= (rem_r == RW'(1));
            dig_r      <= {dig_r[DW-5:0], 4'd0};
            rem_r      <= rem_r - RW'(1);
            if (rem_r == RW'(1)) begin
              fsm_r <= S_IDLE;
            end
          end
        end
        default: begin
          fsm_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last      = out_last_r;

`ifndef SYNTHESIS
  a_hex_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_cmd == FMT_HEX) |=> (fsm_r == S_PRE0))
    else $error("hex beat did not start with the prefix");

  a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
    (fsm_r == S_EMIT) |-> (rem_r != '0))
    else $error("emitting with no digits left");

  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_char_code >= 7'h30 && out_char_code <= 7'h39) ||
                   (out_char_code >= 7'h61 && out_char_code <= 7'h66) ||
                   (out_char_code == CH_X)))
    else $error("character code out of range");
`endif

endmodule

`default_nettype wire

// ----- verif/b2a_checker.sv -----
`timescale 1ns / 100ps
// Checker for the binary to ASCII number formatter: watches both channels, predicts the text
// of every accepted number and compares each output beat with the oldest expected character.
// Depends on b2a_pkg for field widths and ASCII codes.
module b2a_checker #(
  parameter int VALUE_BITS = b2a_pkg::DEF_VALUE_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  input  wire logic                           in_ready,
  input  wire logic                           in_cmd,
  input  wire logic [b2a_pkg::IN_VALUE_W-1:0] in_value,
  input  wire logic                           out_valid,
  input  wire logic                           out_ready,
  input  wire logic [b2a_pkg::CHAR_W-1:0]     out_char_code,
  input  wire logic                           out_last,
  output int                                  fail_count,
  output int                                  chars_pending,
  output int                                  chars_checked
);
  import b2a_pkg::*;

  localparam int HEX_NIBBLES = (VALUE_BITS + 3) / 4;
  localparam int DEC_MAX_DIGITS = 20;
  localparam logic [CHAR_W-1:0] CH_A_LOWER = 7'h61;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  text_char_t expected_chars[$];
  int errors = 0;
  int checked = 0;

  function automatic logic [IN_VALUE_W-1:0] used_bits(input logic [IN_VALUE_W-1:0] v);
    logic [IN_VALUE_W-1:0] mask;
    mask = (VALUE_BITS >= IN_VALUE_W) ? '1 : ((IN_VALUE_W'(1) << VALUE_BITS) - 1);
    return v & mask;
  endfunction

  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
    return (nib < 4'd10) ? CH_ZERO + CHAR_W'(nib) : CH_A_LOWER + CHAR_W'(nib - 4'd10);
  endfunction

  function automatic void format_number_text(input logic fmt,
                                             input logic [IN_VALUE_W-1:0] value);
    logic [IN_VALUE_W-1:0] v;
    logic [3:0] digits[DEC_MAX_DIGITS];
    int n;
    v = used_bits(value);
    n = 0;
    if (fmt == FMT_HEX) begin
      expected_chars.push_back(text_char_t'{CH_ZERO, 1'b0});
      expected_chars.push_back(text_char_t'{CH_X, 1'b0});
      for (int i = HEX_NIBBLES - 1; i >= 0; i--) begin
        expected_chars.push_back(text_char_t'{hex_char(4'(v >> (i * 4))), i == 0});
      end
    end else if (v == '0) begin
      expected_chars.push_back(text_char_t'{CH_ZERO, 1'b1});
    end else begin
      while (v != '0 && n < DEC_MAX_DIGITS) begin
        digits[n] = 4'(v % 10);
        v = v / 10;
        n++;
      end
      for (int i = n - 1; i >= 0; i--) begin
        expected_chars.push_back(text_char_t'{CH_ZERO + CHAR_W'(digits[i]), i == 0});
      end
    end
  endfunction

  always @(posedge clk) begin : watch
    text_char_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        format_number_text(in_cmd, in_value);
      end
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          $error("Unexpected beat: char_code %h, last %b", out_char_code, out_last);
          errors++;
        end else begin
          want = expected_chars.pop_front();
          checked++;
          if (out_char_code !== want.code) begin
            $error("char_code mismatch: expected %h, actual %h", want.code, out_char_code);
            errors++;
          end
          if (out_last !== want.last) begin
            $error("last mismatch: expected %b, actual %b", want.last, out_last);
            errors++;
          end
        end
      end
    end
    fail_count <= errors;
    chars_pending <= expected_chars.size();
    chars_checked <= checked;
  end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// Top of the testbench for the binary to ASCII number formatter: drives numbers in both
// formats with random gaps and receiver stalls, and reports the checker's verdict.
// Depends on b2a_pkg, binary_to_ascii_number_formatter and b2a_checker.
module tb_top;
  import b2a_pkg::*;

  localparam int MAX_GAP = 11;
  localparam int HOLD_CYCLES = 500;
  localparam int DRAIN_CYCLES = 120;
  localparam int STALL_LIMIT = 5000;
  localparam int PHASE_ITEMS = 60;
  localparam int PHASES = 6;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_cmd;
  logic [IN_VALUE_W-1:0] in_value;
  logic                  out_valid;
  logic                  out_ready;
  logic [CHAR_W-1:0]     out_char_code;
  logic                  out_last;

  int fail_count;
  int chars_pending;
  int chars_checked;

  logic send_idle = 1'b1;
  logic recv_idle = 1'b1;
  int   dec_sent = 0;
  int   hex_sent = 0;
  int   beats_taken = 0;
  int   holds_done = 0;
  int   idle_cycles = 0;
  logic [IN_VALUE_W-1:0] pow10[20];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  binary_to_ascii_number_formatter u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char_code(out_char_code),
    .out_last     (out_last)
  );

  b2a_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char_code(out_char_code),
    .out_last     (out_last),
    .fail_count   (fail_count),
    .chars_pending(chars_pending),
    .chars_checked(chars_checked)
  );

  task automatic send_number(input logic fmt, input logic [IN_VALUE_W-1:0] value);
    int gap;
    gap = send_idle ? $urandom_range(0, MAX_GAP) : 0;
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= fmt;
    in_value <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (fmt == FMT_HEX) hex_sent++;
    else dec_sent++;
  endtask

  function automatic logic [IN_VALUE_W-1:0] random_value();
    logic [IN_VALUE_W-1:0] v;
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: v = '0;
      1: v = pow10[$urandom_range(0, 19)] + IN_VALUE_W'($urandom_range(0, 2)) - 1;
      2: v = '1 >> $urandom_range(0, 63);
      default: v = {$urandom, $urandom} >> $urandom_range(0, 63);
    endcase
    return v;
  endfunction

  initial begin : receiver
    int gap;
    out_ready = 1'b0;
    forever begin
      gap = recv_idle ? $urandom_range(0, MAX_GAP) : 0;
      if (beats_taken == 150 || beats_taken == 2000) begin
        gap = HOLD_CYCLES;
        holds_done++;
      end
      repeat (gap) begin
        out_ready <= 1'b0;
        @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      beats_taken++;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    logic [IN_VALUE_W-1:0] p;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = FMT_DEC;
    in_value = '0;
    p = 1;
    for (int i = 0; i < 20; i++) begin
      pow10[i] = p;
      p = p * 10;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_number(FMT_DEC, '0);
    send_number(FMT_DEC, 64'd1);
    send_number(FMT_DEC, 64'd9);
    send_number(FMT_DEC, 64'd10);
    send_number(FMT_DEC, 64'd99);
    send_number(FMT_DEC, 64'd100);
    send_number(FMT_DEC, 64'd1234567890);
    send_number(FMT_DEC, '1);
    send_number(FMT_DEC, pow10[19]);
    send_number(FMT_DEC, pow10[19] - 1);
    send_number(FMT_DEC, 64'h8000_0000_0000_0000);
    send_number(FMT_HEX, '0);
    send_number(FMT_HEX, '1);
    send_number(FMT_HEX, 64'h0123_4567_89ab_cdef);
    send_number(FMT_HEX, 64'hfedc_ba98_7654_3210);
    send_number(FMT_HEX, 64'h8000_0000_0000_0001);
    send_number(FMT_HEX, 64'h0f0f_0f0f_a5a5_5a5a);
    send_number(FMT_DEC, 64'h5555_5555_5555_5555);
    send_number(FMT_HEX, 64'haaaa_aaaa_aaaa_aaaa);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin send_idle = 1'b1; recv_idle = 1'b1; end
        1: begin send_idle = 1'b0; recv_idle = 1'b0; end
        2: begin send_idle = 1'b1; recv_idle = 1'b0; end
        default: begin send_idle = 1'b0; recv_idle = 1'b1; end
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        send_number($urandom_range(0, 1) ? FMT_HEX : FMT_DEC, random_value());
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (chars_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Summary: %0d numbers converted (%0d decimal, %0d hex), %0d characters checked.",
             dec_sent + hex_sent, dec_sent, hex_sent, chars_checked);
    $display("Receiver held off %0d times for %0d cycles while the sender kept offering.",
             holds_done, HOLD_CYCLES);
    if (fail_count == 0 && chars_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
